FILE: rtl/core/ptom_pkg.sv
// Package for the piece table offset mapper.
// Entry type, operation and status codes, controller states. No dependencies.
`timescale 1ns / 1ps

package ptom_pkg;

    localparam int PT_MAX_PIECES = 256;

    typedef struct packed {
        logic        src;
        logic [31:0] start;
        logic [31:0] len;
    } t_entry;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_READ   = 2'd1,
        OP_INSERT = 2'd2,
        OP_DELETE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SC_RD,
        S_SC_CK,
        S_DECIDE,
        S_PUT,
        S_SH_RD,
        S_SH_WR,
        S_RESP
    } t_state;

endpackage

FILE: rtl/core/ptom_if.sv
// Valid/ready channel interfaces for the piece table offset mapper.
// Depends on nothing.
`timescale 1ns / 1ps

interface ptom_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] offset;
    logic [31:0] length;
    modport source (output valid, op, offset, length, input ready);
    modport sink (input valid, op, offset, length, output ready);
endinterface

interface ptom_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        src;
    logic [31:0] phys_addr;
    logic [31:0] logical_size;
    modport source (output valid, status, src, phys_addr, logical_size, input ready);
    modport sink (input valid, status, src, phys_addr, logical_size, output ready);
endinterface

FILE: rtl/core/piece_table_offset_mapper.sv
// Piece table offset mapper top level: controller, scan and shift engine.
// Depends on ptom_pkg, ptom_if and ptom_mem.
//
// One transaction in, one result out; one operation at a time. Load sets up at
// most one piece and responds. Read, insert and delete with an offset inside the
// table walk the piece memory from entry 0, reading then comparing each piece,
// until the target piece is found, then insert and delete move the trailing
// entries through the single memory port pair, reading then writing each entry,
// plus one write per rewritten entry. No clearing pass after reset.
`timescale 1ns / 1ps

module piece_table_offset_mapper import ptom_pkg::*; #(
    parameter int MAX_PIECES = PT_MAX_PIECES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ptom_in_if.sink       i_in,
    ptom_out_if.source    o_out
);

    localparam int AW = $clog2(MAX_PIECES);
    localparam int CW = $clog2(MAX_PIECES + 1);
    localparam logic [CW:0] MAXC = (CW+1)'(MAX_PIECES);

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic [31:0] r_off, n_off, r_len, n_len, r_end, n_end;
    logic [31:0] r_total, n_total, r_au, n_au, r_base, n_base;
    logic [CW-1:0] r_count, n_count, r_i, n_i, r_s, n_s, r_e, n_e;
    logic [CW-1:0] r_j, n_j, r_stop, n_stop, r_dist, n_dist;
    logic [31:0] r_sr, n_sr, r_er, n_er;
    t_entry r_es, n_es, r_ee, n_ee;
    logic r_fs, n_fs, r_fe, n_fe;
    logic [2:0] r_pv, n_pv;
    logic [AW-1:0] r_pa [3];
    logic [AW-1:0] n_pa [3];
    t_entry r_pd [3];
    t_entry n_pd [3];
    logic r_post, n_post, r_shp, n_shp, r_up, n_up;
    t_status r_status, n_status;
    logic r_src, n_src;
    logic [31:0] r_phys, n_phys;

    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    t_entry        w_wdata, w_rdata;

    ptom_mem #(.DEPTH(MAX_PIECES), .AW(AW)) u_mem (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    logic acc;
    assign acc = i_in.valid && i_in.ready;

    // scan compare
    logic [32:0] c_sum;
    logic c_hit_s, c_fs_now, c_need_e, c_hit_e, c_done, c_last;
    always_comb begin
        c_sum    = {1'b0, r_base} + {1'b0, w_rdata.len};
        c_hit_s  = !r_fs && ({1'b0, r_off} < c_sum);
        c_fs_now = r_fs || c_hit_s;
        c_need_e = (r_op == OP_DELETE) && (r_end != r_total);
        c_hit_e  = c_need_e && c_fs_now && !r_fe && ({1'b0, r_end} < c_sum);
        c_done   = c_need_e ? (r_fe || c_hit_e) : c_fs_now;
        c_last   = (r_i + CW'(1)) == r_count;
    end

    // decision on scan results
    logic d_fail, d_any_put, d_shift;
    logic [32:0] d_au_sum, d_tot_sum;
    logic [CW:0] d_cnt_need;
    logic d_app, d_two, d_same, d_e_valid;
    logic [CW-1:0] d_e, d_first;
    logic [31:0] d_er, d_right;
    always_comb begin
        d_au_sum   = {1'b0, r_au} + {1'b0, r_len};
        d_tot_sum  = {1'b0, r_total} + {1'b0, r_len};
        d_app      = (r_off >= r_total) || !r_fs;
        d_two      = !d_app && (r_sr != 32'd0);
        d_cnt_need = {1'b0, r_count} + (d_two ? (CW+1)'(2) : (CW+1)'(1));
        d_e_valid  = c_need_e && r_fe;
        d_e        = d_e_valid ? r_e : r_count;
        d_er       = d_e_valid ? r_er : 32'd0;
        d_same     = d_e_valid && (r_e == r_s);
        d_right    = r_es.len - d_er;
        d_first    = (r_sr != 32'd0) ? r_s + CW'(1) : r_s;
        d_fail     = 1'b0;
        if (r_op == OP_INSERT) begin
            d_fail = d_au_sum[32] || d_tot_sum[32] || (d_cnt_need > MAXC);
        end else if (r_op == OP_DELETE) begin
            d_fail = !r_fs || (d_same && (r_sr != 32'd0) && (d_right != 32'd0) &&
                     (({1'b0, r_count} + (CW+1)'(1)) > MAXC));
        end
        d_any_put = |n_pv;
        d_shift   = n_shp;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (t_op'(i_in.op))
                        OP_LOAD: n_state = S_PUT;
                        OP_READ: n_state = (i_in.offset >= r_total) ? S_RESP :
                                           (r_count == '0) ? S_DECIDE : S_SC_RD;
                        OP_INSERT: n_state = (i_in.length == 32'd0) ? S_RESP :
                                             (i_in.offset >= r_total || r_count == '0) ?
                                             S_DECIDE : S_SC_RD;
                        default: n_state = (i_in.length == 32'd0 ||
                                            i_in.offset >= r_total) ? S_RESP :
                                           (r_count == '0) ? S_DECIDE : S_SC_RD;
                    endcase
                end
            end
            S_SC_RD: n_state = S_SC_CK;
            S_SC_CK: n_state = (c_done || c_last) ? S_DECIDE : S_SC_RD;
            S_DECIDE: begin
                if (r_op == OP_READ || d_fail) begin
                    n_state = S_RESP;
                end else if (!n_post && d_any_put) begin
                    n_state = S_PUT;
                end else if (d_shift) begin
                    n_state = S_SH_RD;
                end else if (d_any_put) begin
                    n_state = S_PUT;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_PUT: begin
                if (n_pv == 3'b000) begin
                    n_state = (!r_post && r_shp) ? S_SH_RD : S_RESP;
                end
            end
            S_SH_RD: n_state = S_SH_WR;
            S_SH_WR: begin
                if (r_j == r_stop) begin
                    n_state = (r_post && (r_pv != 3'b000)) ? S_PUT : S_RESP;
                end else begin
                    n_state = S_SH_RD;
                end
            end
            S_RESP: if (o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_op = r_op; n_off = r_off; n_len = r_len; n_end = r_end;
        n_total = r_total; n_au = r_au; n_count = r_count;
        n_i = r_i; n_base = r_base; n_fs = r_fs; n_fe = r_fe;
        n_s = r_s; n_sr = r_sr; n_es = r_es; n_e = r_e; n_er = r_er; n_ee = r_ee;
        n_pv = r_pv; n_pa = r_pa; n_pd = r_pd;
        n_post = r_post; n_shp = r_shp; n_up = r_up;
        n_j = r_j; n_stop = r_stop; n_dist = r_dist;
        n_status = r_status; n_src = r_src; n_phys = r_phys;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_op = t_op'(i_in.op);
                    n_off = i_in.offset;
                    n_len = i_in.length;
                    n_end = ({1'b0, i_in.offset} + {1'b0, i_in.length} >
                             {1'b0, r_total}) ? r_total : i_in.offset + i_in.length;
                    n_i = '0; n_base = '0; n_fs = 1'b0; n_fe = 1'b0;
                    n_pv = 3'b000; n_post = 1'b0; n_shp = 1'b0;
                    n_status = ST_OK; n_src = 1'b0; n_phys = 32'd0;
                    case (t_op'(i_in.op))
                        OP_LOAD: begin
                            n_au = 32'd0;
                            n_total = i_in.length;
                            n_count = (i_in.length != 32'd0) ? CW'(1) : '0;
                            n_pv = {2'b00, i_in.length != 32'd0};
                            n_pa[0] = '0;
                            n_pd[0] = '{src: 1'b0, start: 32'd0, len: i_in.length};
                        end
                        OP_READ: if (i_in.offset >= r_total) n_status = ST_RANGE;
                        OP_INSERT: ;
                        default: if (i_in.length != 32'd0 && i_in.offset >= r_total)
                            n_status = ST_RANGE;
                    endcase
                end
            end
            S_SC_CK: begin
                if (c_hit_s) begin
                    n_fs = 1'b1; n_s = r_i; n_sr = r_off - r_base; n_es = w_rdata;
                end
                if (c_hit_e) begin
                    n_fe = 1'b1; n_e = r_i; n_er = r_end - r_base; n_ee = w_rdata;
                end
                n_i = r_i + CW'(1);
                n_base = c_sum[31:0];
            end
            S_DECIDE: begin
                case (r_op)
                    OP_READ: begin
                        if (r_fs) begin
                            n_src = r_es.src;
                            n_phys = r_es.start + r_sr;
                        end else begin
                            n_status = ST_RANGE;
                        end
                    end
                    OP_INSERT: begin
                        if (d_fail) begin
                            n_status = ST_FULL;
                        end else begin
                            n_phys = r_au;
                            n_au = d_au_sum[31:0];
                            n_total = d_tot_sum[31:0];
                            n_count = d_cnt_need[CW-1:0];
                            n_post = 1'b1;
                            n_up = 1'b1;
                            n_j = r_count - CW'(1);
                            if (d_two) begin
                                n_dist = CW'(2);
                                n_stop = r_s + CW'(1);
                                n_shp = (r_s + CW'(1)) < r_count;
                                n_pv = 3'b111;
                                n_pa[0] = r_s[AW-1:0];
                                n_pa[1] = AW'(r_s + CW'(1));
                                n_pa[2] = AW'(r_s + CW'(2));
                                n_pd[0] = '{src: r_es.src, start: r_es.start, len: r_sr};
                                n_pd[1] = '{src: 1'b1, start: r_au, len: r_len};
                                n_pd[2] = '{src: r_es.src, start: r_es.start + r_sr,
                                            len: r_es.len - r_sr};
                            end else begin
                                n_dist = CW'(1);
                                n_stop = d_app ? r_count : r_s;
                                n_shp = !d_app;
                                n_pv = 3'b001;
                                n_pa[0] = d_app ? AW'(r_count) : r_s[AW-1:0];
                                n_pd[0] = '{src: 1'b1, start: r_au, len: r_len};
                            end
                        end
                    end
                    OP_DELETE: begin
                        if (!r_fs) begin
                            n_status = ST_RANGE;
                        end else if (d_fail) begin
                            n_status = ST_FULL;
                        end else begin
                            n_total = r_total - (r_end - r_off);
                            if (d_same) begin
                                if (r_sr != 32'd0 && d_right != 32'd0) begin
                                    n_post = 1'b1; n_up = 1'b1; n_dist = CW'(1);
                                    n_j = r_count - CW'(1);
                                    n_stop = r_s + CW'(1);
                                    n_shp = (r_s + CW'(1)) < r_count;
                                    n_count = r_count + CW'(1);
                                    n_pv = 3'b011;
                                    n_pa[0] = r_s[AW-1:0];
                                    n_pa[1] = AW'(r_s + CW'(1));
                                    n_pd[0] = '{src: r_es.src, start: r_es.start, len: r_sr};
                                    n_pd[1] = '{src: r_es.src, start: r_es.start + d_er,
                                                len: d_right};
                                end else if (r_sr != 32'd0) begin
                                    n_pv = 3'b001;
                                    n_pa[0] = r_s[AW-1:0];
                                    n_pd[0] = '{src: r_es.src, start: r_es.start, len: r_sr};
                                end else if (d_right != 32'd0) begin
                                    n_pv = 3'b001;
                                    n_pa[0] = r_s[AW-1:0];
                                    n_pd[0] = '{src: r_es.src, start: r_es.start + d_er,
                                                len: d_right};
                                end else begin
                                    n_up = 1'b0; n_dist = CW'(1);
                                    n_j = r_s + CW'(1);
                                    n_stop = r_count - CW'(1);
                                    n_shp = (r_s + CW'(1)) < r_count;
                                    n_count = r_count - CW'(1);
                                end
                            end else begin
                                n_pv = {1'b0, d_e_valid && (d_er != 32'd0), r_sr != 32'd0};
                                n_pa[0] = r_s[AW-1:0];
                                n_pd[0] = '{src: r_es.src, start: r_es.start, len: r_sr};
                                n_pa[1] = d_e[AW-1:0];
                                n_pd[1] = '{src: r_ee.src, start: r_ee.start + d_er,
                                            len: r_ee.len - d_er};
                                n_up = 1'b0;
                                n_dist = d_e - d_first;
                                n_j = d_e;
                                n_stop = r_count - CW'(1);
                                n_shp = (d_e != d_first) && (d_e < r_count);
                                n_count = r_count - (d_e - d_first);
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_PUT: begin
                if (r_pv[0]) n_pv[0] = 1'b0;
                else if (r_pv[1]) n_pv[1] = 1'b0;
                else n_pv[2] = 1'b0;
            end
            S_SH_WR: begin
                if (r_j == r_stop) n_shp = 1'b0;
                else n_j = r_up ? r_j - CW'(1) : r_j + CW'(1);
            end
            default: ;
        endcase
    end

    // memory port and handshake outputs
    always_comb begin
        w_we = 1'b0;
        w_waddr = '0;
        w_wdata = r_pd[0];
        w_raddr = (r_state == S_SH_RD) ? r_j[AW-1:0] : r_i[AW-1:0];
        if (r_state == S_PUT) begin
            w_we = |r_pv;
            if (r_pv[0]) begin
                w_waddr = r_pa[0]; w_wdata = r_pd[0];
            end else if (r_pv[1]) begin
                w_waddr = r_pa[1]; w_wdata = r_pd[1];
            end else begin
                w_waddr = r_pa[2]; w_wdata = r_pd[2];
            end
        end else if (r_state == S_SH_WR) begin
            w_we = 1'b1;
            w_waddr = r_up ? AW'(r_j + r_dist) : AW'(r_j - r_dist);
            w_wdata = w_rdata;
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = (r_state == S_RESP);
    assign o_out.status       = r_status;
    assign o_out.src          = r_src;
    assign o_out.phys_addr    = r_phys;
    assign o_out.logical_size = r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_total <= 32'd0;
            r_au    <= 32'd0;
            r_pv    <= 3'b000;
            r_shp   <= 1'b0;
            r_post  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_total <= n_total;
            r_au    <= n_au;
            r_pv    <= n_pv;
            r_shp   <= n_shp;
            r_post  <= n_post;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_off <= n_off; r_len <= n_len; r_end <= n_end;
        r_i <= n_i; r_base <= n_base; r_fs <= n_fs; r_fe <= n_fe;
        r_s <= n_s; r_sr <= n_sr; r_es <= n_es;
        r_e <= n_e; r_er <= n_er; r_ee <= n_ee;
        r_pa <= n_pa; r_pd <= n_pd;
        r_up <= n_up; r_j <= n_j; r_stop <= n_stop; r_dist <= n_dist;
        r_status <= n_status; r_src <= n_src; r_phys <= n_phys;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_count} <= MAXC)
        else $error("piece count above table size");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SC_RD || r_state == S_SC_CK) |-> !w_we)
        else $error("memory write during scan");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input ready while a transaction is in flight");

endmodule

FILE: rtl/core/ptom_mem.sv
// Piece entry memory: one write port, one read port, registered read data.
// Depends on ptom_pkg.
`timescale 1ns / 1ps

module ptom_mem import ptom_pkg::*; #(
    parameter int DEPTH = PT_MAX_PIECES,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
